// ===== hdl/pnvd_pkg.sv =====
// Package for the page-number value decoder: widths, style codes, character
// codes, the item and result structs and the roman letter weighting function.
// Depends on nothing; every other file of the block uses it.
package pnvd_pkg;

  localparam int SLOT_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int STYLE_W = 3;
  localparam int VALUE_W = 32;
  localparam int TABLE_W = 24;
  localparam int ROMAN_W = 10;

  localparam logic [TABLE_W-1:0] STYLE_TABLE_RESET = 24'd17500;

  // Style codes held in the slot table; other codes behave as none.
  localparam logic [STYLE_W-1:0] STYLE_NONE    = 3'd0;
  localparam logic [STYLE_W-1:0] STYLE_LOWER   = 3'd1;
  localparam logic [STYLE_W-1:0] STYLE_UPPER   = 3'd2;
  localparam logic [STYLE_W-1:0] STYLE_DECIMAL = 3'd3;
  localparam logic [STYLE_W-1:0] STYLE_ROMAN   = 3'd4;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_V     = 8'h76;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;

  localparam logic [CHAR_W-1:0]  CASE_OFFSET  = 8'h20;
  localparam logic [VALUE_W-1:0] LOWER_OFFSET = 32'd96;
  localparam logic [VALUE_W-1:0] UPPER_OFFSET = 32'd64;
  localparam logic [VALUE_W-1:0] POS_MAX      = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] MAG_LIMIT    = 32'h8000_0000;

  typedef enum logic [1:0] {
    DP_BLANKS = 2'd0,
    DP_DIGITS = 2'd1,
    DP_DONE   = 2'd2,
    DP_ENDED  = 2'd3
  } dec_phase_t;

  typedef struct packed {
    logic [SLOT_W-1:0] style_slot;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] page_value;
    logic                      saturated;
  } result_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    fold = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFFSET : c;
  endfunction

  // Weight of letter c given the letter p before it; both already folded.
  function automatic logic [ROMAN_W-1:0] roman_amount(input logic [CHAR_W-1:0] c,
                                                      input logic [CHAR_W-1:0] p,
                                                      input logic first);
    logic p_xlcdm;
    logic p_cdm;
    p_cdm   = (p == CH_C) || (p == CH_D) || (p == CH_M);
    p_xlcdm = p_cdm || (p == CH_X) || (p == CH_L);
    case (c)
      CH_I: roman_amount = 10'd1;
      CH_V: roman_amount = first ? 10'd5 :
                           (p == CH_I) ? 10'd3 : (p_xlcdm ? 10'd5 : 10'd0);
      CH_X: roman_amount = first ? 10'd10 :
                           (p == CH_I) ? 10'd8 : (p_xlcdm ? 10'd10 : 10'd0);
      CH_L: roman_amount = first ? 10'd50 :
                           (p == CH_X) ? 10'd30 : (p_cdm ? 10'd50 : 10'd0);
      CH_C: roman_amount = first ? 10'd100 :
                           (p == CH_X) ? 10'd80 : (p_cdm ? 10'd100 : 10'd0);
      CH_D: roman_amount = first ? 10'd500 :
                           (p == CH_C) ? 10'd300 : ((p == CH_M) ? 10'd500 : 10'd0);
      CH_M: roman_amount = first ? 10'd1000 :
                           (p == CH_C) ? 10'd800 : ((p == CH_M) ? 10'd1000 : 10'd0);
      default: roman_amount = 10'd0;
    endcase
  endfunction

endpackage

// ===== hdl/pnvd_ifs.sv =====
// Channel interfaces of the page-number value decoder: the character
// channel and the page value channel, each with source and sink modports.
// Depends on pnvd_pkg for the field widths.
interface pnvd_char_if;
  logic                          valid;
  logic                          ready;
  logic [pnvd_pkg::SLOT_W-1:0]   style_slot;
  logic [pnvd_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, style_slot, char_code, last_char, input ready);
  modport sink   (input valid, style_slot, char_code, last_char, output ready);
endinterface

interface pnvd_page_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pnvd_pkg::VALUE_W-1:0]  page_value;
  logic                                 saturated;

  modport source (output valid, page_value, saturated, input ready);
  modport sink   (input valid, page_value, saturated, output ready);
endinterface

// ===== hdl/pnvd_in_stage.sv =====
// Input register of the page-number value decoder: takes one character
// transfer and holds it until the decode stage consumes it.
// Depends on pnvd_pkg and the pnvd_char_if interface.
module pnvd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  pnvd_char_if.sink            chars,
  input  logic                 advance,
  output logic                 item_valid,
  output pnvd_pkg::item_t      item
);
  import pnvd_pkg::*;

  // Free when empty or when the held character leaves in this cycle.
  assign chars.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.ready) begin
      item_valid <= chars.valid;
    end
    if (chars.valid && chars.ready) begin
      item.style_slot <= chars.style_slot;
      item.char_code  <= chars.char_code;
      item.last_char  <= chars.last_char;
    end
  end

endmodule

// ===== hdl/pnvd_decode.sv =====
// String state and per-character update of the page-number value decoder.
// Works out the next state and, on the last character, the page value.
// Depends on pnvd_pkg.
module pnvd_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pnvd_pkg::TABLE_W-1:0]   style_table,
  input  logic                           advance,
  input  pnvd_pkg::item_t                item,
  output pnvd_pkg::result_t              result
);
  import pnvd_pkg::*;

  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [CHAR_W-1:0]  previous_char, previous_char_next;
  logic               at_string_start;
  logic [STYLE_W-1:0] latched_style;
  dec_phase_t         decimal_phase, decimal_phase_next;
  logic               decimal_negative, decimal_negative_next;
  logic               overflow_seen, overflow_seen_next;

  logic [7:0][STYLE_W-1:0] slots;
  logic [STYLE_W-1:0]      style;
  logic [CHAR_W-1:0]       c;
  logic                    is_digit;
  logic                    is_blank;
  logic [35:0]             dec_sum;
  logic [VALUE_W-1:0]      dec_acc;
  logic                    dec_ovf;
  logic [VALUE_W:0]        rom_sum;

  assign slots = style_table;
  assign style = at_string_start ? slots[item.style_slot] : latched_style;
  assign c     = item.char_code;

  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

  // Times ten plus digit, saturated at the magnitude limit.
  assign dec_sum = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
                   + {32'd0, c[3:0]};
  assign dec_ovf = dec_sum > {4'd0, MAG_LIMIT};
  assign dec_acc = dec_ovf ? MAG_LIMIT : dec_sum[VALUE_W-1:0];

  assign rom_sum = {1'b0, accumulator}
                   + {{(VALUE_W+1-ROMAN_W){1'b0}},
                      roman_amount(fold(c), fold(previous_char), at_string_start)};

  always_comb begin
    accumulator_next      = accumulator;
    previous_char_next    = previous_char;
    decimal_phase_next    = decimal_phase;
    decimal_negative_next = decimal_negative;
    overflow_seen_next    = overflow_seen;
    if (decimal_phase != DP_ENDED) begin
      case (style)
        STYLE_LOWER: begin
          if (at_string_start) accumulator_next = {24'd0, c} - LOWER_OFFSET;
        end
        STYLE_UPPER: begin
          if (at_string_start) accumulator_next = {24'd0, c} - UPPER_OFFSET;
        end
        STYLE_DECIMAL: begin
          case (decimal_phase)
            DP_BLANKS: begin
              if (is_blank) begin
                decimal_phase_next = DP_BLANKS;
              end else if (c == CH_PLUS) begin
                decimal_phase_next = DP_DIGITS;
              end else if (c == CH_MINUS) begin
                decimal_negative_next = 1'b1;
                decimal_phase_next    = DP_DIGITS;
              end else if (is_digit) begin
                accumulator_next   = dec_acc;
                overflow_seen_next = overflow_seen || dec_ovf;
                decimal_phase_next = DP_DIGITS;
              end else begin
                decimal_phase_next = DP_DONE;
              end
            end
            DP_DIGITS: begin
              if (is_digit) begin
                accumulator_next   = dec_acc;
                overflow_seen_next = overflow_seen || dec_ovf;
              end else begin
                decimal_phase_next = DP_DONE;
              end
            end
            default: begin
              decimal_phase_next = decimal_phase;
            end
          endcase
        end
        STYLE_ROMAN: begin
          if (rom_sum > {1'b0, POS_MAX}) begin
            accumulator_next   = POS_MAX;
            overflow_seen_next = 1'b1;
          end else begin
            accumulator_next = rom_sum[VALUE_W-1:0];
          end
        end
        default: begin
          accumulator_next = accumulator;
        end
      endcase
      previous_char_next = c;
      if (c == CH_NUL) decimal_phase_next = DP_ENDED;
    end
  end

  always_comb begin
    result.page_value = '0;
    result.saturated  = 1'b0;
    case (style)
      STYLE_LOWER, STYLE_UPPER: begin
        result.page_value = accumulator_next;
      end
      STYLE_DECIMAL: begin
        if (decimal_negative_next) begin
          if (overflow_seen_next) begin
            result.page_value = MAG_LIMIT;
            result.saturated  = 1'b1;
          end else begin
            result.page_value = '0 - accumulator_next;
          end
        end else if (overflow_seen_next || accumulator_next[VALUE_W-1]) begin
          result.page_value = POS_MAX;
          result.saturated  = 1'b1;
        end else begin
          result.page_value = accumulator_next;
        end
      end
      STYLE_ROMAN: begin
        result.page_value = accumulator_next;
        result.saturated  = overflow_seen_next;
      end
      default: begin
        result.page_value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_char)) begin
      accumulator      <= '0;
      previous_char    <= CH_NUL;
      at_string_start  <= 1'b1;
      latched_style    <= STYLE_NONE;
      decimal_phase    <= DP_BLANKS;
      decimal_negative <= 1'b0;
      overflow_seen    <= 1'b0;
    end else if (advance) begin
      accumulator      <= accumulator_next;
      previous_char    <= previous_char_next;
      at_string_start  <= 1'b0;
      latched_style    <= style;
      decimal_phase    <= decimal_phase_next;
      decimal_negative <= decimal_negative_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

endmodule

// ===== hdl/pnvd_out_stage.sv =====
// Result register of the page-number value decoder: holds one page value
// until the sink takes it.
// Depends on pnvd_pkg and the pnvd_page_if interface.
module pnvd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pnvd_pkg::result_t    result,
  pnvd_page_if.source          pages
);
  import pnvd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages.valid <= 1'b0;
    end else if (load) begin
      pages.valid <= 1'b1;
    end else if (pages.ready) begin
      pages.valid <= 1'b0;
    end
    if (load) begin
      pages.page_value <= result.page_value;
      pages.saturated  <= result.saturated;
    end
  end

endmodule

// ===== hdl/page_number_value_decoder.sv =====
// Top level of the page-number value decoder: style table register, input
// register, decode stage and result register.
// Depends on pnvd_pkg, pnvd_ifs, pnvd_in_stage, pnvd_decode, pnvd_out_stage.
//
//   Channel   Direction  Carries                               Transfer when
//   chars     in         style_slot, char_code, last_char      valid && ready
//   pages     out        page_value, saturated                 valid && ready
//   cfg       in         style_table (24 bits)                 cfg_we
//
// One character per cycle is taken in while no last character waits in the
// input register for the result register. A character is folded into the
// string state as it leaves the input register; on the last character the
// page value lands in the result register at that same edge, which needs
// that register free or emptied in that cycle. rst is synchronous and
// clears the string state, both valid flags and the style table (to 17500).
// While a page value waits unread, further characters of the next string are
// still consumed; only a second last character waits in the input register.
module page_number_value_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pnvd_pkg::TABLE_W-1:0]   cfg_wdata,
  pnvd_char_if.sink                      chars,
  pnvd_page_if.source                    pages
);
  import pnvd_pkg::*;

  logic [TABLE_W-1:0] style_table;
  logic               item_valid;
  item_t              item;
  result_t            result;
  logic               advance;

  // The user must rewrite the table only while no string is in flight; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      style_table <= STYLE_TABLE_RESET;
    end else if (cfg_we) begin
      style_table <= cfg_wdata;
    end
  end

  // A character that ends a string needs the result register to be free,
  // or to be emptied in this same cycle; any other character always moves on.
  assign advance = item_valid && (!item.last_char || !pages.valid || pages.ready);

  pnvd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pnvd_decode u_dec (
    .clk         (clk),
    .rst         (rst),
    .style_table (style_table),
    .advance     (advance),
    .item        (item),
    .result      (result)
  );

  pnvd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && item.last_char),
    .result (result),
    .pages  (pages)
  );

endmodule

// ===== hdl/pnvd_checker.sv =====
// Port-level checks for the page-number value decoder, attached to the top
// level by the bind statement at the end of this file.
// Depends on pnvd_pkg and page_number_value_decoder.
module pnvd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_last,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [pnvd_pkg::VALUE_W-1:0]  out_value,
  input logic                                 out_sat
);
  import pnvd_pkg::*;

  // A waiting result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_sat)))
    else $error("page result changed while stalled");

  // A new result follows the transfer of a last character.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("page result without a preceding last character");

  // The input only backs up behind a result that is not being taken.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("character input stalled without a blocked result");

  // A clamped value sits at one end of the signed range.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |->
      (out_value == $signed(POS_MAX) || out_value == $signed(MAG_LIMIT)))
    else $error("saturated flag with a value inside the range");

endmodule

bind page_number_value_decoder pnvd_checker u_pnvd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .in_last   (chars.last_char),
  .out_valid (pages.valid),
  .out_ready (pages.ready),
  .out_value (pages.page_value),
  .out_sat   (pages.saturated)
);
